FILE: rtl/core/bba_pkg.sv
// Package for the buddy block allocator: field widths, status codes and map entry type.
// Used by the channel interfaces and all RTL modules; depends on nothing.
`default_nettype none
package bba_pkg;
  localparam int unsigned GranAddrW = 12;
  localparam int unsigned OrderW = 5;
  localparam logic [4:0] MinOrder = 5'd9;
  localparam logic [4:0] MaxOrder = 5'd16;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_NO_BLOCK = 2'd1,
    STATUS_BAD_FREE = 2'd2
  } status_e;

  // One granule map entry: block start, free flag, log2 of block bytes.
  typedef struct packed {
    logic       start;
    logic       free;
    logic [4:0] order;
  } entry_t;

  typedef struct packed {
    logic        mode;
    logic [15:0] request_bytes;
    logic [15:0] block_address;
  } req_t;

  typedef struct packed {
    logic [15:0] payload_address;
    logic [1:0]  status;
  } rsp_t;
endpackage
`default_nettype wire

FILE: rtl/core/bba_if.sv
// Valid/ready channel interfaces for requests and responses.
// Depends on bba_pkg for the payload types.
`default_nettype none
interface bba_req_if;
  logic           valid;
  logic           ready;
  bba_pkg::req_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bba_rsp_if;
  logic           valid;
  logic           ready;
  bba_pkg::rsp_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/buddy_block_allocator.sv
// Buddy block allocator top level: sequencer around a 4096-entry granule map memory.
// Depends on bba_pkg and the bba_req_if / bba_rsp_if interfaces.
//
// Usage: requests arrive as beats on req (mode, request_bytes, block_address)
// and each produces exactly one response beat on rsp (payload_address,
// status). One request is worked at a time. An allocate scans the granule map
// one entry per cycle over the whole heap (2^heap_order / 16 entries, 32 to
// 4096 entries), then writes one entry per split level. A free reads and
// checks the buddy once per merge level, then writes the merged block.
// After reset, and after every heap_order write, a clearing pass writes all
// 4096 map entries, one per cycle, before req is ready; the heap is then one
// free block. The response sits in an output register: while the receiver
// stalls, the result holds and no new request is taken. cfg_we_i writes
// heap_order (saturated to 9..16) and must only be used while idle.
`default_nettype none
module buddy_block_allocator (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [4:0]  cfg_wdata_i,
  bba_req_if.sink          req,
  bba_rsp_if.source        rsp
);

  typedef enum logic [10:0] {
    ST_CLEAR  = 11'b00000000001,
    ST_IDLE   = 11'b00000000010,
    ST_SCAN   = 11'b00000000100,
    ST_SCANW  = 11'b00000001000,
    ST_SPLIT  = 11'b00000010000,
    ST_FRD    = 11'b00000100000,
    ST_FCHK   = 11'b00001000000,
    ST_BRD    = 11'b00010000000,
    ST_BCHK   = 11'b00100000000,
    ST_FDONE  = 11'b01000000000,
    ST_RESP   = 11'b10000000000
  } state_e;

  state_e state_q, state_d;

  // Granule map memory, registered read.
  bba_pkg::entry_t mem [4096];
  logic [11:0]      rd_addr, wr_addr;
  logic             wr_en;
  bba_pkg::entry_t  wr_data, rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  logic [4:0]  order_q, order_d;
  logic [12:0] cnt_q, cnt_d;       // scan/clear index, one wider than the map
  logic [4:0]  k_q, k_d;
  logic [11:0] best_q, best_d;
  logic [4:0]  bord_q, bord_d;
  logic        found_q, found_d;
  logic [1:0]  nfree_q, nfree_d;   // saturating free block count
  logic [11:0] off_q, off_d;
  logic [4:0]  o_q, o_d;
  logic [11:0] addr_prev_q, addr_prev_d;
  logic        rsp_valid_q, rsp_valid_d;
  bba_pkg::rsp_t rsp_q, rsp_d;

  // Number of granules in the heap, as a scan limit.
  logic [12:0] gran_count;
  assign gran_count = 13'd1 << (order_q - 5'd4);

  // Heap size in bytes, for the free address range check.
  logic [16:0] heap_bytes;
  assign heap_bytes = 17'd1 << order_q;

  // Rounded order for the request: smallest k with 2^k >= bytes + 16.
  logic [16:0] need;
  logic [4:0]  k_calc;
  always_comb begin
    need = {1'b0, req.data.request_bytes} + 17'd16;
    k_calc = 5'd17;
    for (int i = 16; i >= 0; i--) begin
      if ((17'd1 << i) >= need) k_calc = 5'(i);
    end
  end

  logic [15:0] free_off;
  assign free_off = req.data.block_address - 16'd16;

  logic [4:0] cfg_order;
  assign cfg_order = (cfg_wdata_i < bba_pkg::MinOrder) ? bba_pkg::MinOrder :
                     (cfg_wdata_i > bba_pkg::MaxOrder) ? bba_pkg::MaxOrder : cfg_wdata_i;

  logic [11:0] bud;
  assign bud = off_q ^ 12'(17'd1 << (o_q - 5'd4));

  assign req.ready = (state_q == ST_IDLE) && !rsp_valid_q;
  assign rsp.valid = rsp_valid_q;
  assign rsp.data  = rsp_q;

  // Sequencer.
  always_comb begin
    state_d = state_q; order_d = order_q; cnt_d = cnt_q; k_d = k_q;
    best_d = best_q; bord_d = bord_q; found_d = found_q; nfree_d = nfree_q;
    off_d = off_q; o_d = o_q; addr_prev_d = addr_prev_q;
    rsp_valid_d = rsp_valid_q; rsp_d = rsp_q;
    rd_addr = cnt_q[11:0]; wr_en = 1'b0; wr_addr = cnt_q[11:0];
    wr_data = '0;
    if (rsp_valid_q && rsp.ready) rsp_valid_d = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        wr_en = 1'b1;
        wr_data = (cnt_q == 13'd0) ?
                  bba_pkg::entry_t'{start: 1'b1, free: 1'b1, order: order_q} :
                  bba_pkg::entry_t'('0);
        cnt_d = cnt_q + 13'd1;
        if (cnt_q == 13'd4095) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (req.valid && req.ready) begin
          if (!req.data.mode) begin
            k_d = k_calc; found_d = 1'b0; nfree_d = 2'd0; cnt_d = 13'd0;
            rd_addr = 12'd0; state_d = ST_SCAN;
          end else if (({1'b0, free_off} >= heap_bytes) || free_off[3:0] != 4'd0) begin
            rsp_d = '{payload_address: 16'd0, status: bba_pkg::STATUS_BAD_FREE};
            state_d = ST_RESP;
          end else begin
            off_d = free_off[15:4]; rd_addr = free_off[15:4]; state_d = ST_FCHK;
          end
        end
      end
      ST_SCAN: begin
        // Pipeline: read at cnt, evaluate the previous entry.
        rd_addr = cnt_q[11:0];
        addr_prev_d = cnt_q[11:0];
        cnt_d = cnt_q + 13'd1;
        if (cnt_q != 13'd0) begin
          if (rd_q.start && rd_q.free) begin
            if (nfree_q != 2'd2) nfree_d = nfree_q + 2'd1;
            if (rd_q.order >= k_q && (!found_q || rd_q.order < bord_q)) begin
              found_d = 1'b1; bord_d = rd_q.order; best_d = addr_prev_q;
            end
          end
        end
        if (cnt_q + 13'd1 == gran_count) state_d = ST_SCANW;
      end
      ST_SCANW: begin
        // Last entry, then decide.
        logic       f;
        logic [4:0] bo;
        logic [11:0] bb;
        logic [1:0] nf;
        f = found_q; bo = bord_q; bb = best_q; nf = nfree_q;
        if (rd_q.start && rd_q.free) begin
          if (nf != 2'd2) nf = nf + 2'd1;
          if (rd_q.order >= k_q && (!f || rd_q.order < bo)) begin
            f = 1'b1; bo = rd_q.order; bb = addr_prev_q;
          end
        end
        if (gran_count == 13'd1) begin
          f = found_q; bo = bord_q; bb = best_q; nf = nfree_q;
        end
        best_d = bb; bord_d = bo;
        if (!f || (bo == k_q && nf == 2'd1)) begin
          rsp_d = '{payload_address: 16'd0, status: bba_pkg::STATUS_NO_BLOCK};
          state_d = ST_RESP;
        end else begin
          state_d = ST_SPLIT;
        end
      end
      ST_SPLIT: begin
        wr_en = 1'b1;
        if (bord_q > k_q) begin
          bord_d = bord_q - 5'd1;
          wr_addr = best_q | 12'(17'd1 << (bord_q - 5'd5));
          wr_data = '{start: 1'b1, free: 1'b1, order: bord_q - 5'd1};
        end else begin
          wr_addr = best_q;
          wr_data = '{start: 1'b1, free: 1'b0, order: bord_q};
          rsp_d = '{payload_address: {best_q, 4'd0} + 16'd16, status: bba_pkg::STATUS_OK};
          state_d = ST_RESP;
        end
      end
      ST_FCHK: begin
        if (!rd_q.start || rd_q.free) begin
          rsp_d = '{payload_address: 16'd0, status: bba_pkg::STATUS_BAD_FREE};
          state_d = ST_RESP;
        end else begin
          o_d = rd_q.order; state_d = ST_BRD;
        end
      end
      ST_BRD: begin
        if (o_q >= order_q) begin
          state_d = ST_FDONE;
        end else begin
          rd_addr = bud; state_d = ST_BCHK;
        end
      end
      ST_BCHK: begin
        if (rd_q.start && rd_q.free && rd_q.order == o_q) begin
          // Clear the upper of the pair; the lower gets rewritten or cleared later.
          wr_en = 1'b1;
          wr_addr = (off_q < bud) ? bud : off_q;
          wr_data = '0;
          off_d = (off_q < bud) ? off_q : bud;
          o_d = o_q + 5'd1;
          state_d = ST_BRD;
        end else begin
          state_d = ST_FDONE;
        end
      end
      ST_FDONE: begin
        wr_en = 1'b1; wr_addr = off_q;
        wr_data = '{start: 1'b1, free: 1'b1, order: o_q};
        rsp_d = '{payload_address: 16'd0, status: bba_pkg::STATUS_OK};
        state_d = ST_RESP;
      end
      ST_RESP: begin
        rsp_valid_d = 1'b1; state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
    if (cfg_we_i) begin
      order_d = cfg_order; cnt_d = 13'd0; state_d = ST_CLEAR;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR; order_q <= bba_pkg::MaxOrder; cnt_q <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d; order_q <= order_d; cnt_q <= cnt_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q <= k_d; best_q <= best_d; bord_q <= bord_d; found_q <= found_d;
    nfree_q <= nfree_d; off_q <= off_d; o_q <= o_d; addr_prev_q <= addr_prev_d;
    rsp_q <= rsp_d;
  end

endmodule
`default_nettype wire

FILE: verif/buddy_block_allocator_tb.sv
// Testbench for the buddy block allocator: directed and random allocate and free beats,
// checked against a scoreboard that models the granule map. Needs bba_pkg and bba_if.
`timescale 1ns / 100ps

module buddy_block_allocator_tb;
  import bba_pkg::*;

  localparam int unsigned CycleLimit = 4000000;
  localparam int unsigned HoldOffCycles = 400;

  // Scoreboard: its own copy of the heap, and the responses still owed.
  class heap_scoreboard;
    entry_t heap_map[4096];
    int unsigned order;
    rsp_t owed_rsp[$];
    int unsigned fail_count;

    function void set_heap(logic [4:0] v);
      if (v < MinOrder) order = MinOrder;
      else if (v > MaxOrder) order = MaxOrder;
      else order = v;
      foreach (heap_map[i]) heap_map[i] = '0;
      heap_map[0] = '{start: 1'b1, free: 1'b1, order: order[4:0]};
    endfunction

    function rsp_t alloc_block(logic [15:0] req_bytes);
      rsp_t r;
      int unsigned need, k, best_off, best_ord, free_cnt;
      bit found;
      need = req_bytes + 16;
      k = 0;
      found = 0;
      free_cnt = 0;
      best_off = 0;
      best_ord = 0;
      r = '{payload_address: 16'd0, status: STATUS_NO_BLOCK};
      while (k < 20 && (1 << k) < need) k++;
      for (int unsigned off = 0; off < (1 << order); off += 16) begin
        if (heap_map[off >> 4].start && heap_map[off >> 4].free) begin
          free_cnt++;
          if (heap_map[off >> 4].order >= k &&
              (!found || heap_map[off >> 4].order < best_ord)) begin
            found = 1;
            best_ord = heap_map[off >> 4].order;
            best_off = off;
          end
        end
      end
      // Refuse when nothing fits or the only free block would go whole.
      if (!found || (best_ord == k && free_cnt == 1)) return r;
      while (best_ord > k) begin
        best_ord--;
        heap_map[(best_off + (1 << best_ord)) >> 4] =
          '{start: 1'b1, free: 1'b1, order: best_ord[4:0]};
      end
      heap_map[best_off >> 4] = '{start: 1'b1, free: 1'b0, order: best_ord[4:0]};
      r.payload_address = best_off[15:0] + 16'd16;
      r.status = STATUS_OK;
      return r;
    endfunction

    function rsp_t free_block(logic [15:0] addr);
      rsp_t r;
      logic [15:0] off16;
      int unsigned off, bud, o;
      off16 = addr - 16'd16;
      off = off16;
      r = '{payload_address: 16'd0, status: STATUS_BAD_FREE};
      if (off >= (1 << order) || off % 16 != 0) return r;
      if (!heap_map[off >> 4].start || heap_map[off >> 4].free) return r;
      o = heap_map[off >> 4].order;
      // Merge upward while the buddy is a free block of the same size.
      while (o < order) begin
        bud = off ^ (1 << o);
        if (!(heap_map[bud >> 4].start && heap_map[bud >> 4].free &&
              heap_map[bud >> 4].order == o)) break;
        heap_map[off >> 4] = '0;
        heap_map[bud >> 4] = '0;
        if (bud < off) off = bud;
        o++;
      end
      heap_map[off >> 4] = '{start: 1'b1, free: 1'b1, order: o[4:0]};
      r.status = STATUS_OK;
      return r;
    endfunction

    function rsp_t note_request(req_t q);
      rsp_t r;
      r = q.mode ? free_block(q.block_address) : alloc_block(q.request_bytes);
      owed_rsp.push_back(r);
      return r;
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      if (owed_rsp.size() == 0) begin
        $error("response beat with none expected: addr %h status %0d",
               got.payload_address, got.status);
        fail_count++;
        return;
      end
      want = owed_rsp.pop_front();
      if (got.payload_address !== want.payload_address) begin
        $error("payload_address: expected %h, actual %h",
               want.payload_address, got.payload_address);
        fail_count++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        fail_count++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [4:0] cfg_wdata_i;
  bba_req_if req ();
  bba_rsp_if rsp ();

  heap_scoreboard sb;
  logic [15:0] live_addr[$];
  logic [15:0] freed_addr[$];
  bit no_idle;
  bit hold_off_req;
  int unsigned cycle_count;

  buddy_block_allocator u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req        (req.sink),
    .rsp        (rsp.source)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Watchdog on the cycle count.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic int unsigned idle_draw();
    return no_idle ? 0 : $urandom_range(0, 10);
  endfunction

  // Offer one request beat and update the lists of live and freed blocks on acceptance.
  task automatic send_request(req_t q);
    int unsigned w;
    rsp_t r;
    w = idle_draw();
    if (w > 0) begin
      req.valid = 1'b0;
      repeat (w) @(negedge clk_i);
    end
    req.data = q;
    req.valid = 1'b1;
    do @(posedge clk_i); while (!req.ready);
    r = sb.note_request(q);
    if (q.mode && r.status == STATUS_OK) begin
      foreach (live_addr[i]) if (live_addr[i] == q.block_address) begin
        live_addr.delete(i);
        break;
      end
      freed_addr.push_back(q.block_address);
      if (freed_addr.size() > 16) void'(freed_addr.pop_front());
    end else if (!q.mode && r.status == STATUS_OK) begin
      live_addr.push_back(r.payload_address);
    end
    @(negedge clk_i);
  endtask

  task automatic alloc_req(logic [15:0] n);
    send_request('{mode: 1'b0, request_bytes: n, block_address: 16'($urandom)});
  endtask

  task automatic free_req(logic [15:0] a);
    send_request('{mode: 1'b1, request_bytes: 16'($urandom), block_address: a});
  endtask

  // Let every owed response drain, then write the heap order.
  task automatic write_heap_order(logic [4:0] v);
    req.valid = 1'b0;
    while (sb.owed_rsp.size() != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
    cfg_wdata_i = v;
    cfg_we_i = 1'b1;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sb.set_heap(v);
    live_addr.delete();
    freed_addr.delete();
  endtask

  // One random beat: mostly allocs and frees of live blocks, some broken frees.
  task automatic random_beat();
    int unsigned pick;
    int unsigned heap;
    heap = 1 << sb.order;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      if ($urandom_range(0, 9) == 0) alloc_req(16'($urandom));
      else alloc_req(16'($urandom_range(0, heap / 4)));
    end else if (pick < 85 && live_addr.size() > 0) begin
      free_req(live_addr[$urandom_range(0, live_addr.size() - 1)]);
    end else if (pick < 90 && freed_addr.size() > 0) begin
      free_req(freed_addr[$urandom_range(0, freed_addr.size() - 1)]);
    end else if (pick < 95) begin
      free_req(16'($urandom_range(0, heap / 16)) * 16'd16 + 16'($urandom_range(0, 1)) * 16'd8);
    end else begin
      free_req(16'($urandom));
    end
  endtask

  // Response side: random ready gaps, one long hold-off on request.
  initial begin
    int unsigned w;
    rsp.ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      w = idle_draw();
      if (hold_off_req) begin
        w = HoldOffCycles;
        hold_off_req = 0;
      end
      if (w > 0) begin
        rsp.ready = 1'b0;
        repeat (w) @(negedge clk_i);
      end
      rsp.ready = 1'b1;
      do @(posedge clk_i); while (!(rsp.valid && rsp.ready));
      sb.check_response(rsp.data);
      @(negedge clk_i);
    end
  end

  // Main sequence.
  initial begin
    logic [4:0] orders[8];
    int unsigned counts[8];
    sb = new();
    sb.set_heap(5'd16);
    cycle_count = 0;
    no_idle = 0;
    hold_off_req = 0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = 5'd0;
    req.valid = 1'b0;
    req.data = '0;
    rst_ni = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed at the full 64 KiB heap.
    alloc_req(16'd65520);
    alloc_req(16'hFFFF);
    for (int n = 15; n >= 5; n--) alloc_req(16'((1 << n) - 16));
    free_req(16'd16);
    alloc_req(16'd0);
    alloc_req(16'd0);
    free_req(16'd0);
    free_req(16'd0);
    free_req(16'd17);
    free_req(16'd24);
    free_req(16'd0);

    // Saturation of the written order at both ends.
    write_heap_order(5'd0);
    alloc_req(16'd0);
    alloc_req(16'd496);
    free_req(16'd528);
    free_req(16'd16);
    write_heap_order(5'd31);
    alloc_req(16'd100);
    free_req(16'd16);

    orders = '{5'd9, 5'd12, 5'd10, 5'd11, 5'd13, 5'd9, 5'd16, 5'd10};
    counts = '{180, 170, 180, 180, 120, 180, 25, 180};
    foreach (orders[p]) begin
      write_heap_order(orders[p]);
      no_idle = (p == 3);
      if (p == 1) hold_off_req = 1;
      // Random beats mix allocs with frees so that frees and merges get exercised.
      repeat (counts[p]) random_beat();
    end
    no_idle = 0;

    req.valid = 1'b0;
    while (sb.owed_rsp.size() != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
    if (sb.fail_count == 0 && sb.owed_rsp.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

FILE: filelist.f
rtl/core/bba_pkg.sv
rtl/core/bba_if.sv
rtl/core/buddy_block_allocator.sv
verif/buddy_block_allocator_tb.sv
